[rtl/core/rmst_pkg.sv]
// Package for the range minimum sparse table unit: field widths, mode and
// status codes, the controller state type and the floor log2 helper.
// Depends on nothing; every other file of the block but rmst_table_mem imports it.
`default_nettype none

package rmst_pkg;

  localparam int POS_WIDTH    = 10;
  localparam int MODE_WIDTH   = 2;
  localparam int STATUS_WIDTH = 2;
  localparam int MIN_WIDTH    = 32;
  localparam int LEN_WIDTH    = POS_WIDTH + 1;
  localparam int LOG_WIDTH    = $clog2(LEN_WIDTH);

  localparam logic [MODE_WIDTH-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_QRY_A,
    ST_QRY_B,
    ST_QRY_C,
    ST_FINISH
  } state_t;

  function automatic logic [LOG_WIDTH-1:0] floor_log2(input logic [LEN_WIDTH-1:0] x);
    logic [LOG_WIDTH-1:0] k;
    k = '0;
    for (int i = 1; i < LEN_WIDTH; i++) begin
      if (x[i]) begin
        k = LOG_WIDTH'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rmst_req_if.sv]
// Request channel of the range minimum sparse table unit.
// Carries valid, ready and the request payload; depends on rmst_pkg.
`default_nettype none

interface rmst_req_if #(
  parameter int VALUE_WIDTH = 32
);
  import rmst_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [MODE_WIDTH-1:0]         mode;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [POS_WIDTH-1:0]          left_pos;
  logic [POS_WIDTH-1:0]          right_pos;

  modport source (output valid, mode, value, left_pos, right_pos, input ready);
  modport sink (input valid, mode, value, left_pos, right_pos, output ready);
endinterface

`default_nettype wire

[rtl/core/rmst_rsp_if.sv]
// Response channel of the range minimum sparse table unit.
// Carries valid, ready, the minimum and the status; depends on rmst_pkg.
`default_nettype none

interface rmst_rsp_if;
  import rmst_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [MIN_WIDTH-1:0] minimum;
  logic [STATUS_WIDTH-1:0]     status;

  modport source (output valid, minimum, status, input ready);
  modport sink (input valid, minimum, status, output ready);
endinterface

`default_nettype wire

[rtl/core/range_minimum_sparse_table_unit.sv]
// Range minimum sparse table unit: controller, address generation and result
// register around one table memory. Depends on rmst_pkg, rmst_req_if,
// rmst_rsp_if and rmst_table_mem.
//
// Usage: each request transaction on req carries a mode. Append stores the
// value at the next position and fills every level whose window now ends
// there; query returns the minimum over the inclusive range between
// left_pos and right_pos in either order; clear sets the loaded count to
// zero. Every request yields exactly one response transaction on rsp with
// the minimum and a status (ok, table full, range beyond the count).
// Timing: one request is in work at a time, and req.ready is high only
// while the controller is idle. An append is bound by one memory
// read-modify-write per filled level. A query makes two memory reads in
// sequence. Clear, rejected appends and queries beyond the count go
// straight to the final state. The response is held in an output register;
// a new request is taken while it waits, and the controller only holds in
// its final state when the next response is ready and the previous one has
// not been taken. Reset clears the loaded count and the handshake state;
// table contents are undefined until written and need no clearing pass.
`default_nettype none

module range_minimum_sparse_table_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic  clk,
  input  logic  rst,
  rmst_req_if.sink   req,
  rmst_rsp_if.source rsp
);
  import rmst_pkg::*;

  localparam int PW    = $clog2(MAX_ELEMENTS);
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int LW    = $clog2(LEVELS);
  localparam int AW    = LW + PW;
  localparam int DEPTH = LEVELS << PW;
  localparam int EW    = (CW > LEVELS) ? CW : LEVELS;
  localparam int HW    = (CW > POS_WIDTH) ? CW : POS_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  state_t state, state_next;

  logic [CW-1:0]           count;
  logic [LW-1:0]           lvl;
  logic [PW-1:0]           pos;
  logic [VALUE_WIDTH-1:0]  prev;
  logic [VALUE_WIDTH-1:0]  key_a;
  logic [AW-1:0]           qa_addr;
  logic [AW-1:0]           qb_addr;
  logic [VALUE_WIDTH-1:0]  res_key;
  logic [STATUS_WIDTH-1:0] res_status;

  logic                    out_valid;
  logic [MIN_WIDTH-1:0]    out_min;
  logic [STATUS_WIDTH-1:0] out_status;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;

  logic                   accept;
  logic                   out_space;
  logic                   full;
  logic                   beyond;
  logic [PW-1:0]          pos_new;
  logic [VALUE_WIDTH-1:0] flipped;
  logic [POS_WIDTH-1:0]   lo;
  logic [POS_WIDTH-1:0]   hi;
  logic [LEN_WIDTH-1:0]   len;
  logic [LOG_WIDTH-1:0]   k_raw;
  logic [LOG_WIDTH-1:0]   k_sat;
  logic [LEN_WIDTH-1:0]   b_pos;
  logic [AW-1:0]          qa_addr_c;
  logic [AW-1:0]          qb_addr_c;
  logic [EW-1:0]          p1;
  logic [EW-1:0]          span_cur;
  logic [EW-1:0]          span_nxt;
  logic [PW-1:0]          start_cur;
  logic [PW-1:0]          start_nxt;
  logic                   more_levels;
  logic [VALUE_WIDTH-1:0] lvl_min;
  logic [VALUE_WIDTH-1:0] qry_min;

  rmst_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign out_space   = !out_valid || rsp.ready;
  assign rsp.valid   = out_valid;
  assign rsp.minimum = out_min;
  assign rsp.status  = out_status;

  // Request decode and query address generation.
  always_comb begin
    full      = (count == CW'(MAX_ELEMENTS));
    pos_new   = PW'(count);
    flipped   = {~req.value[VALUE_WIDTH-1], req.value[VALUE_WIDTH-2:0]};
    lo        = (req.left_pos < req.right_pos) ? req.left_pos : req.right_pos;
    hi        = (req.left_pos < req.right_pos) ? req.right_pos : req.left_pos;
    beyond    = (HW'(hi) >= HW'(count));
    len       = LEN_WIDTH'(hi) - LEN_WIDTH'(lo) + LEN_WIDTH'(1);
    k_raw     = floor_log2(len);
    k_sat     = (32'(k_raw) > LEVELS - 1) ? LOG_WIDTH'(LEVELS - 1) : k_raw;
    b_pos     = LEN_WIDTH'(hi) + LEN_WIDTH'(1) - (LEN_WIDTH'(1) << k_sat);
    qa_addr_c = {LW'(k_sat), PW'(lo)};
    qb_addr_c = {LW'(k_sat), PW'(b_pos)};
  end

  // Level fill: the upper half of each window is the entry written one step
  // before, so it is forwarded in prev and only the lower half is read.
  always_comb begin
    p1          = EW'(pos) + EW'(1);
    span_cur    = EW'(1) << lvl;
    span_nxt    = EW'(2) << lvl;
    start_cur   = PW'(p1 - span_cur);
    start_nxt   = PW'(p1 - span_nxt);
    more_levels = (lvl != LW'(LEVELS - 1)) && (p1 >= span_nxt);
    lvl_min     = (rdata < prev) ? rdata : prev;
    qry_min     = (rdata < key_a) ? rdata : key_a;
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = {LW'(0), pos_new};
    wdata      = flipped;
    raddr      = {LW'(0), PW'(pos_new - PW'(1))};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.mode)
            MODE_APPEND: begin
              if (full) begin
                state_next = ST_FINISH;
              end else begin
                we         = 1'b1;
                state_next = (pos_new != '0) ? ST_APPEND : ST_FINISH;
              end
            end
            MODE_QUERY: begin
              raddr      = qa_addr_c;
              state_next = beyond ? ST_FINISH : ST_QRY_A;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_APPEND: begin
        we         = 1'b1;
        waddr      = {lvl, start_cur};
        wdata      = lvl_min;
        raddr      = {lvl, start_nxt};
        state_next = more_levels ? ST_APPEND : ST_FINISH;
      end
      ST_QRY_A: begin
        raddr      = qa_addr;
        state_next = ST_QRY_B;
      end
      ST_QRY_B: begin
        raddr      = qb_addr;
        state_next = ST_QRY_C;
      end
      ST_QRY_C: begin
        raddr      = qb_addr;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = out_space ? ST_IDLE : ST_FINISH;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lvl   <= '0;
    end else if (accept) begin
      lvl <= LW'(1);
      if (req.mode == MODE_APPEND && !full) begin
        count <= count + CW'(1);
      end else if (req.mode == MODE_CLEAR) begin
        count <= '0;
      end
    end else if (state == ST_APPEND) begin
      lvl <= lvl + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos     <= pos_new;
      prev    <= flipped;
      qa_addr <= qa_addr_c;
      qb_addr <= qb_addr_c;
      res_key <= '0;
      if (req.mode == MODE_APPEND && full) begin
        res_status <= STATUS_FULL;
      end else if (req.mode == MODE_QUERY && beyond) begin
        res_status <= STATUS_RANGE;
      end else begin
        res_status <= STATUS_OK;
      end
    end else if (state == ST_APPEND) begin
      prev <= lvl_min;
    end else if (state == ST_QRY_B) begin
      key_a <= rdata;
    end else if (state == ST_QRY_C) begin
      res_key <= qry_min ^ SIGN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_space) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_space) begin
      out_min    <= MIN_WIDTH'(res_key);
      out_status <= res_status;
    end
  end

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_IDLE || state == ST_APPEND))
    else $error("table write outside of an append");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("loaded count exceeds the table size");

  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND) |-> (lvl != '0))
    else $error("level fill at level zero");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_space) |=> (out_valid && state == ST_IDLE))
    else $error("finished transaction did not reach the output register");

  a_query_sequence: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRY_A) |=> (state == ST_QRY_B) ##1 (state == ST_QRY_C))
    else $error("query read sequence broken");

endmodule

`default_nettype wire

[rtl/core/rmst_table_mem.sv]
// Single write port, single read port table memory with registered read data.
// Holds all levels of the sparse table; no dependencies.
`default_nettype none

module rmst_table_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[dv/rmst_answer_checker.sv]
// Checker for the range minimum sparse table unit: watches both channels, keeps
// its own sparse table and loaded count, and compares every response in order.
// Depends on rmst_pkg, rmst_req_if and rmst_rsp_if.
`default_nettype none

module rmst_answer_checker #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst,
  rmst_req_if  req,
  rmst_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);
  import rmst_pkg::*;

  typedef struct packed {
    logic signed [MIN_WIDTH-1:0] minimum;
    logic [STATUS_WIDTH-1:0]     status;
  } rmst_answer_t;

  logic signed [VALUE_WIDTH-1:0] window_min [LEVELS][MAX_ELEMENTS];
  int unsigned                   loaded;
  rmst_answer_t                  awaited_answers[$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] lesser(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic rmst_answer_t answer_for_request(
    input logic [MODE_WIDTH-1:0]         mode,
    input logic signed [VALUE_WIDTH-1:0] value,
    input logic [POS_WIDTH-1:0]          pos_a,
    input logic [POS_WIDTH-1:0]          pos_b
  );
    rmst_answer_t answer;
    int unsigned  span;
    int unsigned  start;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  len;
    int unsigned  level;
    answer = '{minimum: '0, status: STATUS_OK};
    case (mode)
      MODE_APPEND: begin
        if (loaded >= MAX_ELEMENTS) begin
          answer.status = STATUS_FULL;
        end else begin
          window_min[0][loaded] = value;
          for (int k = 1; k < LEVELS; k++) begin
            span = 1 << k;
            if (loaded + 1 < span) break;
            start = loaded + 1 - span;
            window_min[k][start] = lesser(window_min[k-1][start],
                                          window_min[k-1][start + span / 2]);
          end
          loaded++;
        end
      end
      MODE_QUERY: begin
        lo = (pos_a < pos_b) ? pos_a : pos_b;
        hi = (pos_a < pos_b) ? pos_b : pos_a;
        if (hi >= loaded) begin
          answer.status = STATUS_RANGE;
        end else begin
          len   = hi - lo + 1;
          level = 0;
          while (len > 1) begin
            len = len >> 1;
            level++;
          end
          if (level > LEVELS - 1) level = LEVELS - 1;
          answer.minimum = lesser(window_min[level][lo],
                                  window_min[level][hi + 1 - (1 << level)]);
        end
      end
      MODE_CLEAR: begin
        loaded = 0;
      end
      default: begin
      end
    endcase
    return answer;
  endfunction

  always @(posedge clk) begin
    rmst_answer_t oldest;
    if (rst) begin
      loaded = 0;
      awaited_answers.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("response with none awaited: minimum %0d status %0d",
                                    rsp.minimum, rsp.status));
        end else begin
          oldest = awaited_answers.pop_front();
          if (rsp.minimum !== oldest.minimum) begin
            report_mismatch($sformatf("minimum %0d, expected %0d",
                                      rsp.minimum, oldest.minimum));
          end
          if (rsp.status !== oldest.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp.status, oldest.status));
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_answers = {awaited_answers,
                           answer_for_request(req.mode, req.value,
                                              req.left_pos, req.right_pos)};
      end
    end
    outstanding = awaited_answers.size();
  end

endmodule

`default_nettype wire

[dv/range_minimum_sparse_table_unit_test.sv]
// Top of the range minimum sparse table unit testbench: clock, reset, request
// and response stimulus, watchdog and verdict. Depends on rmst_pkg, both
// channel interfaces, the unit itself and rmst_answer_checker.
`default_nettype none

module range_minimum_sparse_table_unit_test;
  import rmst_pkg::*;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int VALUE_WIDTH  = 32;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 18;
  localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        steady;
  int          mismatches;
  int          outstanding;
  int          quiet_cycles;
  int unsigned filled;
  int unsigned issued;

  rmst_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
  rmst_rsp_if rsp_ch ();

  range_minimum_sparse_table_unit #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS(LEVELS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  rmst_answer_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS(LEVELS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("range_minimum_sparse_table_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue_request(
    input logic [MODE_WIDTH-1:0]         mode,
    input logic signed [VALUE_WIDTH-1:0] value,
    input logic [POS_WIDTH-1:0]          pos_a,
    input logic [POS_WIDTH-1:0]          pos_b
  );
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.value     <= value;
    req_ch.left_pos  <= pos_a;
    req_ch.right_pos <= pos_b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (mode == MODE_APPEND && filled < MAX_ELEMENTS) begin
      filled++;
    end else if (mode == MODE_CLEAR) begin
      filled = 0;
    end
    issued++;
  endtask

  task automatic wait_for_answers();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(15)) inside
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return VALUE_WIDTH'($urandom_range(15)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_query_within();
    int unsigned lo;
    int unsigned hi;
    int unsigned reach;
    if ($urandom_range(3) == 0) begin
      reach = (filled > 4) ? 3 : filled - 1;
      lo    = $urandom_range(reach);
      hi    = filled - 1 - $urandom_range(reach);
    end else begin
      lo = $urandom_range(filled - 1);
      hi = $urandom_range(filled - 1);
    end
    if ($urandom_range(1)) begin
      issue_request(MODE_QUERY, $urandom, POS_WIDTH'(lo), POS_WIDTH'(hi));
    end else begin
      issue_request(MODE_QUERY, $urandom, POS_WIDTH'(hi), POS_WIDTH'(lo));
    end
  endtask

  task automatic issue_query_anywhere();
    issue_request(MODE_QUERY, $urandom, POS_WIDTH'($urandom_range(MAX_ELEMENTS - 1)),
                  POS_WIDTH'($urandom_range(MAX_ELEMENTS - 1)));
  endtask

  task automatic run_episode(input int unsigned target, input int unsigned append_pct,
                             input bit drain);
    int unsigned attempts;
    int unsigned pick;
    attempts = 0;
    while (attempts < target) begin
      steady <= (target > MAX_ELEMENTS) && (filled >= 200) && (filled < 500);
      pick = $urandom_range(99);
      if (pick < append_pct) begin
        issue_request(MODE_APPEND, pick_value(), POS_WIDTH'($urandom),
                      POS_WIDTH'($urandom));
        attempts++;
      end else if (pick < 94) begin
        if (filled != 0) begin
          issue_query_within();
        end else begin
          issue_query_anywhere();
        end
      end else if (pick < 98) begin
        issue_query_anywhere();
      end else if (pick == 98 || target > MAX_ELEMENTS) begin
        issue_request(MODE_UNUSED, $urandom, POS_WIDTH'($urandom), POS_WIDTH'($urandom));
      end else begin
        issue_request(MODE_CLEAR, $urandom, POS_WIDTH'($urandom), POS_WIDTH'($urandom));
      end
    end
    steady <= 1'b0;
    if (filled != 0) begin
      repeat ($urandom_range(2, 6)) issue_query_within();
      issue_request(MODE_QUERY, $urandom, POS_WIDTH'(filled - 1), '0);
    end
    if (drain) wait_for_answers();
    issue_request(MODE_CLEAR, $urandom, POS_WIDTH'($urandom), POS_WIDTH'($urandom));
  endtask

  initial begin
    logic signed [VALUE_WIDTH-1:0] seed_values [8];
    int unsigned                   stop_at;
    seed_values = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
                    32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd100};
    rst              <= 1'b1;
    steady           <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= MODE_APPEND;
    req_ch.value     <= '0;
    req_ch.left_pos  <= '0;
    req_ch.right_pos <= '0;
    filled = 0;
    issued = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_request(MODE_QUERY, '0, 10'd0, 10'd0);
    issue_request(MODE_UNUSED, 32'shFFFF_FFFF, 10'h3FF, 10'h3FF);
    foreach (seed_values[i]) issue_request(MODE_APPEND, seed_values[i], 10'd0, 10'd0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd0);
    issue_request(MODE_QUERY, '0, 10'd7, 10'd0);
    issue_request(MODE_QUERY, '0, 10'd1, 10'd1);
    issue_request(MODE_QUERY, '0, 10'd2, 10'd7);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd2);
    issue_request(MODE_QUERY, '0, 10'd6, 10'd5);
    issue_request(MODE_QUERY, '0, 10'd8, 10'd0);
    issue_request(MODE_QUERY, '0, 10'h3FF, 10'h3FF);
    issue_request(MODE_QUERY, '0, 10'd0, 10'h3FF);
    issue_request(MODE_UNUSED, '0, 10'd0, 10'd0);
    issue_request(MODE_CLEAR, '0, 10'd0, 10'd0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd0);
    issue_request(MODE_APPEND, 32'sd42, 10'd0, 10'd0);
    issue_request(MODE_QUERY, '0, 10'd0, 10'd0);

    stop_at = issued + RANDOM_ITEMS;
    run_episode($urandom_range(8, 40), 55, 1'b0);
    run_episode(MAX_ELEMENTS + 6, 90, 1'b1);
    while (issued < stop_at) begin
      run_episode($urandom_range(1, 40), 55, $urandom_range(1));
    end

    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("range_minimum_sparse_table_unit_test: clean");
    end else begin
      $display("range_minimum_sparse_table_unit_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/rmst_pkg.sv
rtl/core/rmst_req_if.sv
rtl/core/rmst_rsp_if.sv
rtl/core/rmst_table_mem.sv
rtl/core/range_minimum_sparse_table_unit.sv
dv/rmst_answer_checker.sv
dv/range_minimum_sparse_table_unit_test.sv
